/* hw/rtl/cfq_pkg.sv */
`default_nettype none

package cfq_pkg;

  localparam int unsigned SlotCountDefault = 16;
  localparam int unsigned CapW             = 4;
  localparam int unsigned WordW            = 32;
  localparam logic [CapW-1:0] CapacityReset = 4'd15;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [WordW-1:0] push_value;
  } cfq_in_t;

  typedef struct packed {
    logic                    accepted;
    logic signed [WordW-1:0] oldest_value;
    logic signed [WordW-1:0] newest_value;
    logic [CapW-1:0]         entry_count;
    logic                    is_empty;
    logic                    is_full;
  } cfq_out_t;

endpackage

`default_nettype wire

/* hw/rtl/circular_fifo_queue_unit.sv */
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    in_data_i (cmd, push_value)
// out      output     out_valid_o / out_ready_i  out_data_o (status and peeks)
// cfg      input      cfg_we_i                   cfg_data_i (capacity)
//
// Each item is accepted in S_IDLE: its push is written to the slot memory and the new
// head entry is read into the memory's registered read port. In S_READ the result is
// loaded into the output register; no new input is taken until that has happened.
// Reset empties the queue and sets the capacity to 15; the slot memory is not cleared.
// A capacity write also empties the queue.
// A stalled output holds the finished item in the output register, and the next item
// is still accepted; it then waits in its read cycle until the output register frees.
`default_nettype none

module circular_fifo_queue_unit import cfq_pkg::*; #(
  parameter int unsigned SlotCount = SlotCountDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire cfq_in_t         in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output cfq_out_t             out_data_o,
  input  wire logic            cfg_we_i,
  input  wire logic [CapW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(SlotCount);
  localparam int unsigned SzW  = (IdxW + 1 > CapW + 1) ? IdxW + 1 : CapW + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CapW-1:0]   capacity_q;
  logic [IdxW-1:0]   rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]   wr_idx_q, wr_idx_d;
  logic [WordW-1:0]  newest_q;
  logic              acc_q, acc_d;
  logic              fwd_q, fwd_d;
  logic              out_valid_q;
  cfq_out_t          out_q, res;

  logic [WordW-1:0]  mem_q [SlotCount];
  logic [WordW-1:0]  rdata_q;
  logic              mem_we;
  logic              accept;
  logic              load_out;

  logic [SzW-1:0]    ring_full, ring_size;
  logic [IdxW-1:0]   wr_next, rd_next;
  logic              empty_now, full_now;
  logic [SzW-1:0]    cnt_wide;

  function automatic logic [IdxW-1:0] advance(logic [IdxW-1:0] i, logic [SzW-1:0] m);
    logic [SzW-1:0] nxt;
    nxt = SzW'(i) + SzW'(1);
    return (nxt >= m) ? '0 : nxt[IdxW-1:0];
  endfunction

  // Ring uses capacity plus one slots, limited to the physical store.
  assign ring_full = SzW'(capacity_q) + SzW'(1);
  assign ring_size = (ring_full > SzW'(SlotCount)) ? SzW'(SlotCount) : ring_full;

  assign wr_next   = advance(wr_idx_q, ring_size);
  assign rd_next   = advance(rd_idx_q, ring_size);
  assign empty_now = (rd_idx_q == wr_idx_q);
  assign full_now  = (wr_next == rd_idx_q);
  assign cnt_wide  = (wr_idx_q >= rd_idx_q) ? SzW'(wr_idx_q) - SzW'(rd_idx_q)
                                            : SzW'(wr_idx_q) + ring_size - SzW'(rd_idx_q);

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign load_out   = (state_q == S_READ) & (~out_valid_q | out_ready_i);

  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    wr_idx_d = wr_idx_q;
    acc_d    = acc_q;
    fwd_d    = fwd_q;
    mem_we   = 1'b0;
    if (accept) begin
      state_d = S_READ;
      acc_d   = 1'b1;
      fwd_d   = 1'b0;
      unique case (in_data_i.cmd)
        CMD_PUSH: begin
          if (full_now) begin
            acc_d = 1'b0;
          end else begin
            mem_we   = 1'b1;
            wr_idx_d = wr_next;
            // A push onto an empty queue becomes the head, so its value is forwarded to the result.
            fwd_d    = empty_now;
          end
        end
        CMD_POP: begin
          if (empty_now) begin
            acc_d = 1'b0;
          end else begin
            rd_idx_d = rd_next;
          end
        end
        default: ;
      endcase
    end else if (load_out) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      capacity_q  <= CapacityReset;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      acc_q       <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      fwd_q   <= fwd_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_data_i;
        rd_idx_q   <= '0;
        wr_idx_q   <= '0;
      end else begin
        rd_idx_q <= rd_idx_d;
        wr_idx_q <= wr_idx_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Slot memory: one write port and one registered read port at the new head.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx_q] <= in_data_i.push_value;
    end
    if (accept) begin
      rdata_q <= mem_q[rd_idx_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      newest_q <= in_data_i.push_value;
    end
    if (load_out) begin
      out_q <= res;
    end
  end

  always_comb begin
    res.accepted     = acc_q;
    res.oldest_value = empty_now ? '0 : (fwd_q ? newest_q : rdata_q);
    res.newest_value = empty_now ? '0 : newest_q;
    res.entry_count  = cnt_wide[CapW-1:0];
    res.is_empty     = empty_now;
    res.is_full      = full_now;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* hw/rtl/cfq_checker.sv */
`default_nettype none

module cfq_checker import cfq_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire cfq_out_t out_data_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_empty |-> out_data_o.entry_count == '0)
    else $error("empty queue reports entries");

  a_empty_peek: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_empty |->
      out_data_o.oldest_value == '0 && out_data_o.newest_value == '0)
    else $error("empty queue peeks are not zero");

  a_filled_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_empty |-> out_data_o.entry_count != '0)
    else $error("filled queue reports zero entries");

endmodule

bind circular_fifo_queue_unit cfq_checker u_cfq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
